>>> design/wmtsc_pkg.sv
// Shared types, constants and register codes for the watch mode and time-set controller.
`timescale 1ns / 1ps

package wmtsc_pkg;

   // Timer and counter widths
   localparam int TIMER_BITS   = 16;
   localparam int CNT_BITS     = TIMER_BITS + 1;
   localparam int CNT_IDX_BITS = $clog2(CNT_BITS);
   localparam int CFG_BITS     = 16;
   localparam int PCT_BITS     = 7;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0]   COUNT_MAX = {CNT_BITS{1'b1}};

   // Register reset values
   localparam logic [CFG_BITS-1:0] DISPLAY_ON_RST   = 16'd5000;
   localparam logic [CFG_BITS-1:0] BLINK_PERIOD_RST = 16'd125;
   localparam logic [CFG_BITS-1:0] SET_TIMEOUT_RST  = 16'd30000;
   localparam logic [CFG_BITS-1:0] BATTERY_SHOW_RST = 16'd3000;
   localparam logic [PCT_BITS-1:0] LOW_BATTERY_RST  = 7'd25;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DISPLAY_ON   = 3'd0,
      CSR_BLINK_PERIOD = 3'd1,
      CSR_SET_TIMEOUT  = 3'd2,
      CSR_BATTERY_SHOW = 3'd3,
      CSR_LOW_BATTERY  = 3'd4
   } csr_index_type;

   // Watch modes
   typedef enum logic [1:0] {
      MODE_TIME  = 2'd0,
      MODE_SET   = 2'd1,
      MODE_BATT  = 2'd2,
      MODE_SLEEP = 2'd3
   } mode_type;

   // Button events
   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_SW1_SHORT = 3'd1,
      EV_SW1_LONG  = 3'd2,
      EV_SW2_SHORT = 3'd3,
      EV_SW2_LONG  = 3'd4
   } event_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] display_on_ms;
      logic [CFG_BITS-1:0] blink_period_ms;
      logic [CFG_BITS-1:0] set_timeout_ms;
      logic [CFG_BITS-1:0] battery_show_ms;
      logic [PCT_BITS-1:0] low_battery_pct;
   } cfg_type;

   typedef struct packed {
      logic [2:0]          button_event;
      logic [4:0]          clock_hours;
      logic [5:0]          clock_minutes;
      logic [PCT_BITS-1:0] battery_percent;
   } req_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic                blink_phase;
      logic [2:0]          edit_position;
      logic [1:0]          hours_tens;
      logic [3:0]          hours_units;
      logic [2:0]          minutes_tens;
      logic [3:0]          minutes_units;
      logic [PCT_BITS-1:0] battery_level;
      logic                battery_blank;
      logic                write_time;
      logic [4:0]          write_hours;
      logic [5:0]          write_minutes;
   } rsp_type;

   // Blink phase recompute status
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [CFG_BITS-1:0] rem;
      logic                odd;
   } blink_div_type;

endpackage

>>> design/wmtsc_if.sv
// Request and response channel interfaces of the watch controller.
`timescale 1ns / 1ps

interface wmtsc_req_if;
   import wmtsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          button_event;
   logic [4:0]          clock_hours;
   logic [5:0]          clock_minutes;
   logic [PCT_BITS-1:0] battery_percent;

   modport source (output valid, button_event, clock_hours, clock_minutes, battery_percent,
                   input ready);
   modport sink (input valid, button_event, clock_hours, clock_minutes, battery_percent,
                 output ready);
endinterface

interface wmtsc_rsp_if;
   import wmtsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic                blink_phase;
   logic [2:0]          edit_position;
   logic [1:0]          hours_tens;
   logic [3:0]          hours_units;
   logic [2:0]          minutes_tens;
   logic [3:0]          minutes_units;
   logic [PCT_BITS-1:0] battery_level;
   logic                battery_blank;
   logic                write_time;
   logic [4:0]          write_hours;
   logic [5:0]          write_minutes;

   modport source (output valid, mode, blink_phase, edit_position, hours_tens, hours_units,
                   minutes_tens, minutes_units, battery_level, battery_blank, write_time,
                   write_hours, write_minutes,
                   input ready);
   modport sink (input valid, mode, blink_phase, edit_position, hours_tens, hours_units,
                 minutes_tens, minutes_units, battery_level, battery_blank, write_time,
                 write_hours, write_minutes,
                 output ready);
endinterface

>>> design/wmtsc_csr.sv
// Configuration register file of the watch controller.
`timescale 1ns / 1ps

module wmtsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [wmtsc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [wmtsc_pkg::CFG_BITS-1:0]      csr_wdata,
   output wmtsc_pkg::cfg_type                  cfg,
   output logic                                blink_wr
);
   import wmtsc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    blink_wr_ff, blink_wr_in;

   // Register write decode
   always_comb begin
      cfg_in      = cfg_ff;
      blink_wr_in = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DISPLAY_ON:   cfg_in.display_on_ms = csr_wdata;
            CSR_BLINK_PERIOD: begin
               cfg_in.blink_period_ms = csr_wdata;
               blink_wr_in            = 1'b1;
            end
            CSR_SET_TIMEOUT:  cfg_in.set_timeout_ms  = csr_wdata;
            CSR_BATTERY_SHOW: cfg_in.battery_show_ms = csr_wdata;
            CSR_LOW_BATTERY:  cfg_in.low_battery_pct = csr_wdata[PCT_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_on_ms   <= DISPLAY_ON_RST;
         cfg_ff.blink_period_ms <= BLINK_PERIOD_RST;
         cfg_ff.set_timeout_ms  <= SET_TIMEOUT_RST;
         cfg_ff.battery_show_ms <= BATTERY_SHOW_RST;
         cfg_ff.low_battery_pct <= LOW_BATTERY_RST;
         blink_wr_ff            <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         blink_wr_ff <= blink_wr_in;
      end
   end

   assign cfg      = cfg_ff;
   assign blink_wr = blink_wr_ff;

endmodule

>>> design/wmtsc_blink_div.sv
// Bit-serial divider that recomputes the battery blink phase after a period change.
`timescale 1ns / 1ps

module wmtsc_blink_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wmtsc_pkg::CFG_BITS-1:0]    period,
   input  logic [wmtsc_pkg::CNT_BITS-1:0]    dividend,
   output wmtsc_pkg::blink_div_type          status
);
   import wmtsc_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [CNT_IDX_BITS-1:0] idx_ff;
   logic [CFG_BITS-1:0]     rem_ff;
   logic                    odd_ff;

   logic [CFG_BITS-1:0] per;
   logic [CFG_BITS:0]   shifted;
   logic [CFG_BITS:0]   diff;
   logic                fits;

   // One restoring step: a zero period counts as one
   always_comb begin
      per     = (period == '0) ? CFG_BITS'(1) : period;
      shifted = {rem_ff, dividend[idx_ff]};
      fits    = (shifted >= {1'b0, per});
      diff    = shifted - {1'b0, per};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
         rem_ff  <= '0;
         odd_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= CNT_IDX_BITS'(CNT_BITS - 1);
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[CFG_BITS-1:0] : shifted[CFG_BITS-1:0];
            odd_ff <= fits;
            if (idx_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff - CNT_IDX_BITS'(1);
            end
         end
      end
   end

   assign status.busy = busy_ff | start;
   assign status.done = done_ff;
   assign status.rem  = rem_ff;
   assign status.odd  = odd_ff;

endmodule

>>> design/wmtsc_core.sv
// Mode state machine, timers and digit editing of the watch controller.
`timescale 1ns / 1ps

module wmtsc_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  wmtsc_pkg::req_type              req,
   input  wmtsc_pkg::cfg_type              cfg,
   input  wmtsc_pkg::blink_div_type        div,
   output logic [wmtsc_pkg::CNT_BITS-1:0]  blink_count,
   output wmtsc_pkg::rsp_type              rsp
);
   import wmtsc_pkg::*;

   localparam logic [3:0] HT_LIMIT      = 4'd2;
   localparam logic [3:0] HU_LIMIT_20S  = 4'd3;
   localparam logic [3:0] DEC_LIMIT     = 4'd9;
   localparam logic [3:0] MT_LIMIT      = 4'd5;
   localparam logic [1:0] HT_TWENTY     = 2'd2;
   localparam logic [2:0] EDIT_DONE     = 3'd4;
   localparam logic [6:0] HOURS_SAT     = 7'd31;
   localparam logic [6:0] MINUTES_SAT   = 7'd63;
   localparam logic [1:0] POS_HT        = 2'd0;
   localparam logic [1:0] POS_HU        = 2'd1;
   localparam logic [1:0] POS_MT        = 2'd2;

   // Saturate a configured time to the timer width
   function automatic logic [TIMER_BITS-1:0] clip_t(input logic [CFG_BITS-1:0] v);
      logic [TIMER_BITS-1:0] r;
      if (33'(v) > 33'(TIMER_MAX)) r = TIMER_MAX;
      else r = TIMER_BITS'(v);
      return r;
   endfunction

   function automatic logic [TIMER_BITS-1:0] inc_t(input logic [TIMER_BITS-1:0] v);
      return (v == TIMER_MAX) ? TIMER_MAX : v + TIMER_BITS'(1);
   endfunction

   function automatic logic [TIMER_BITS-1:0] dec_t(input logic [TIMER_BITS-1:0] v);
      return (v == '0) ? '0 : v - TIMER_BITS'(1);
   endfunction

   // Tens digit of a value up to 63 by reciprocal multiply
   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [13:0] prod;
      prod = 14'(v) * 14'd205;
      return prod[13:11];
   endfunction

   mode_type              mode_ff, mode_in;
   logic [TIMER_BITS-1:0] disp_rem_ff, disp_rem_in;
   logic [TIMER_BITS-1:0] blink_el_ff, blink_el_in;
   logic                  blink_on_ff, blink_on_in;
   logic [TIMER_BITS-1:0] idle_el_ff, idle_el_in;
   logic [2:0]            edit_idx_ff, edit_idx_in;
   logic [1:0]            dig0_ff, dig0_in;
   logic [3:0]            dig1_ff, dig1_in;
   logic [2:0]            dig2_ff, dig2_in;
   logic [3:0]            dig3_ff, dig3_in;
   logic [4:0]            saved_h_ff, saved_h_in;
   logic [5:0]            saved_m_ff, saved_m_in;
   logic [PCT_BITS-1:0]   batt_lat_ff, batt_lat_in;
   logic [TIMER_BITS-1:0] batt_rem_ff, batt_rem_in;
   logic [CNT_BITS-1:0]   bcnt_ff, bcnt_in;
   logic [CFG_BITS-1:0]   bsub_ff, bsub_in;
   logic                  bpar_ff, bpar_in;

   logic       wr;
   logic [4:0] wh;
   logic [5:0] wm;
   logic       blank;

   // Next state
   always_comb begin
      event_type           ev;
      logic [2:0]          ht;
      logic [2:0]          mt;
      logic [3:0]          cur;
      logic [3:0]          lim;
      logic [3:0]          nv;
      logic [2:0]          edit_nx;
      logic [6:0]          hsum;
      logic [6:0]          msum;
      logic                done;
      logic [CFG_BITS-1:0] per;
      logic [CFG_BITS-1:0] sub_nx;

      mode_in     = mode_ff;
      disp_rem_in = disp_rem_ff;
      blink_el_in = blink_el_ff;
      blink_on_in = blink_on_ff;
      idle_el_in  = idle_el_ff;
      edit_idx_in = edit_idx_ff;
      dig0_in     = dig0_ff;
      dig1_in     = dig1_ff;
      dig2_in     = dig2_ff;
      dig3_in     = dig3_ff;
      saved_h_in  = saved_h_ff;
      saved_m_in  = saved_m_ff;
      batt_lat_in = batt_lat_ff;
      batt_rem_in = batt_rem_ff;
      bcnt_in     = bcnt_ff;
      bsub_in     = bsub_ff;
      bpar_in     = bpar_ff;
      wr          = 1'b0;
      wh          = '0;
      wm          = '0;
      blank       = 1'b0;

      // Unknown event codes count as no press
      unique case (req.button_event)
         EV_NONE, EV_SW1_SHORT, EV_SW1_LONG, EV_SW2_SHORT, EV_SW2_LONG:
            ev = event_type'(req.button_event);
         default: ev = EV_NONE;
      endcase

      ht      = tens_of({1'b0, req.clock_hours});
      mt      = tens_of(req.clock_minutes);
      cur     = '0;
      lim     = DEC_LIMIT;
      nv      = '0;
      edit_nx = edit_idx_ff + 3'd1;
      hsum    = 7'(dig0_ff) * 7'd10 + 7'(dig1_ff);
      msum    = 7'(dig2_ff) * 7'd10 + 7'(dig3_ff);
      done    = 1'b0;
      per     = (cfg.blink_period_ms == '0) ? CFG_BITS'(1) : cfg.blink_period_ms;
      sub_nx  = bsub_ff + CFG_BITS'(1);

      if (step_en) begin
         unique case (mode_ff)
            MODE_TIME: begin
               case (ev)
                  EV_SW1_LONG: begin
                     saved_h_in  = req.clock_hours;
                     saved_m_in  = req.clock_minutes;
                     dig0_in     = ht[1:0];
                     dig1_in     = 4'(req.clock_hours - 5'(ht) * 5'd10);
                     dig2_in     = mt;
                     dig3_in     = 4'(req.clock_minutes - 6'(mt) * 6'd10);
                     edit_idx_in = '0;
                     idle_el_in  = '0;
                     blink_on_in = 1'b1;
                     blink_el_in = '0;
                     mode_in     = MODE_SET;
                  end
                  EV_SW2_LONG: begin
                     batt_lat_in = req.battery_percent;
                     batt_rem_in = clip_t(cfg.battery_show_ms);
                     bcnt_in     = '0;
                     bsub_in     = '0;
                     bpar_in     = 1'b0;
                     mode_in     = MODE_BATT;
                  end
                  EV_SW1_SHORT, EV_SW2_SHORT: begin
                     disp_rem_in = clip_t(cfg.display_on_ms);
                  end
                  default: begin
                     disp_rem_in = dec_t(disp_rem_ff);
                     if (disp_rem_in == '0) mode_in = MODE_SLEEP;
                  end
               endcase
            end

            MODE_SET: begin
               // Free-running blink
               blink_el_in = inc_t(blink_el_ff);
               if (33'(blink_el_in) >= 33'(cfg.blink_period_ms)) begin
                  blink_on_in = ~blink_on_ff;
                  blink_el_in = '0;
               end
               case (ev)
                  EV_SW1_SHORT: begin
                     // Step the edited digit with its wrap limit
                     case (edit_idx_ff[1:0])
                        POS_HT: begin
                           cur = 4'(dig0_ff);
                           lim = HT_LIMIT;
                        end
                        POS_HU: begin
                           cur = dig1_ff;
                           lim = (dig0_ff == HT_TWENTY) ? HU_LIMIT_20S : DEC_LIMIT;
                        end
                        POS_MT: begin
                           cur = 4'(dig2_ff);
                           lim = MT_LIMIT;
                        end
                        default: begin
                           cur = dig3_ff;
                           lim = DEC_LIMIT;
                        end
                     endcase
                     nv = cur + 4'd1;
                     if (nv > lim) nv = '0;
                     case (edit_idx_ff[1:0])
                        POS_HT:  dig0_in = nv[1:0];
                        POS_HU:  dig1_in = nv;
                        POS_MT:  dig2_in = nv[2:0];
                        default: dig3_in = nv;
                     endcase
                     idle_el_in  = '0;
                     blink_on_in = 1'b1;
                     blink_el_in = '0;
                  end
                  EV_SW2_SHORT: begin
                     edit_idx_in = edit_nx;
                     idle_el_in  = '0;
                     if (edit_nx >= EDIT_DONE) begin
                        wr          = 1'b1;
                        wh          = (hsum > HOURS_SAT) ? HOURS_SAT[4:0] : hsum[4:0];
                        wm          = (msum > MINUTES_SAT) ? MINUTES_SAT[5:0] : msum[5:0];
                        mode_in     = MODE_TIME;
                        disp_rem_in = clip_t(cfg.display_on_ms);
                        done        = 1'b1;
                     end else begin
                        blink_on_in = 1'b1;
                        blink_el_in = '0;
                     end
                  end
                  default: idle_el_in = inc_t(idle_el_ff);
               endcase
               // Idle timeout cancels and restores the snapshot
               if (!done && (33'(idle_el_in) >= 33'(cfg.set_timeout_ms))) begin
                  wr          = 1'b1;
                  wh          = saved_h_ff;
                  wm          = saved_m_ff;
                  mode_in     = MODE_TIME;
                  disp_rem_in = clip_t(cfg.display_on_ms);
               end
            end

            MODE_BATT: begin
               // Blink count kept as remainder and quotient parity
               if (bcnt_ff != COUNT_MAX) begin
                  bcnt_in = bcnt_ff + CNT_BITS'(1);
                  if (sub_nx >= per) begin
                     bsub_in = '0;
                     bpar_in = ~bpar_ff;
                  end else begin
                     bsub_in = sub_nx;
                  end
               end
               batt_rem_in = dec_t(batt_rem_ff);
               if (batt_rem_in == '0) begin
                  mode_in     = MODE_TIME;
                  disp_rem_in = clip_t(cfg.display_on_ms);
               end else if (batt_lat_ff < cfg.low_battery_pct) begin
                  blank = bpar_in;
               end
            end

            default: begin
               if (ev != EV_NONE) begin
                  mode_in     = MODE_TIME;
                  disp_rem_in = clip_t(cfg.display_on_ms);
               end
            end
         endcase
      end else if (div.done) begin
         bsub_in = div.rem;
         bpar_in = div.odd;
      end
   end

   // Result fields from the updated state
   always_comb begin
      rsp.mode          = mode_in;
      rsp.blink_phase   = (mode_in == MODE_SET) ? blink_on_in : 1'b0;
      rsp.edit_position = edit_idx_in;
      rsp.hours_tens    = dig0_in;
      rsp.hours_units   = dig1_in;
      rsp.minutes_tens  = dig2_in;
      rsp.minutes_units = dig3_in;
      rsp.battery_level = batt_lat_in;
      rsp.battery_blank = blank;
      rsp.write_time    = wr;
      rsp.write_hours   = wh;
      rsp.write_minutes = wm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TIME;
         disp_rem_ff <= clip_t(DISPLAY_ON_RST);
         blink_el_ff <= '0;
         blink_on_ff <= 1'b1;
         idle_el_ff  <= '0;
         edit_idx_ff <= '0;
         dig0_ff     <= '0;
         dig1_ff     <= '0;
         dig2_ff     <= '0;
         dig3_ff     <= '0;
         saved_h_ff  <= '0;
         saved_m_ff  <= '0;
         batt_lat_ff <= '0;
         batt_rem_ff <= '0;
         bcnt_ff     <= '0;
         bsub_ff     <= '0;
         bpar_ff     <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         disp_rem_ff <= disp_rem_in;
         blink_el_ff <= blink_el_in;
         blink_on_ff <= blink_on_in;
         idle_el_ff  <= idle_el_in;
         edit_idx_ff <= edit_idx_in;
         dig0_ff     <= dig0_in;
         dig1_ff     <= dig1_in;
         dig2_ff     <= dig2_in;
         dig3_ff     <= dig3_in;
         saved_h_ff  <= saved_h_in;
         saved_m_ff  <= saved_m_in;
         batt_lat_ff <= batt_lat_in;
         batt_rem_ff <= batt_rem_in;
         bcnt_ff     <= bcnt_in;
         bsub_ff     <= bsub_in;
         bpar_ff     <= bpar_in;
      end
   end

   assign blink_count = bcnt_ff;

endmodule

>>> design/watch_mode_and_time_set_control_core.sv
// Top level of the watch mode and time-set controller.
`timescale 1ns / 1ps
//
// One request per millisecond tick carries a button event, the current clock time and a
// battery reading; each request gives exactly one response with the mode, the edited digits,
// the blink phase, battery blanking and a time-write strobe for the clock.
// Requests enter on req_chan (valid/ready), responses leave on rsp_chan (valid/ready).
// Registers are written through csr_wr_en / csr_index / csr_wdata at any clock edge with
// csr_wr_en high; the user must write them only while no request is in flight, since the
// block itself does not enforce this. A request passes from acceptance into the input
// register, then through the mode update into the response register. Throughput: one
// request per cycle while the receiver takes responses and no blink recompute runs.
// A write to the blink period register starts a bit-serial recompute of the battery
// blink phase; req_chan.ready is low while it runs.
// Reset (synchronous, active high) loads the register defaults, enters show time with the
// display timer full and empties both pipeline registers.
// When the receiver stalls, the response register holds; the input register still takes one
// more request, after which ready drops until the response is taken.

module watch_mode_and_time_set_control_core (
   input  logic                               clock,
   input  logic                               reset,
   wmtsc_req_if.sink                          req_chan,
   wmtsc_rsp_if.source                        rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [wmtsc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [wmtsc_pkg::CFG_BITS-1:0]     csr_wdata
);
   import wmtsc_pkg::*;

   cfg_type             cfg;
   logic                blink_wr;
   blink_div_type       div_status;
   logic [CNT_BITS-1:0] blink_count;
   rsp_type             rsp_next;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    advance;
   logic    req_take;

   wmtsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .blink_wr  (blink_wr)
   );

   wmtsc_blink_div u_blink_div (
      .clock    (clock),
      .reset    (reset),
      .start    (blink_wr),
      .period   (cfg.blink_period_ms),
      .dividend (blink_count),
      .status   (div_status)
   );

   wmtsc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .req         (in_data_ff),
      .cfg         (cfg),
      .div         (div_status),
      .blink_count (blink_count),
      .rsp         (rsp_next)
   );

   // Pipeline handshake
   always_comb begin
      advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
      req_take = req_chan.valid && req_chan.ready;

      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      in_data_in = in_data_ff;
      if (req_take) begin
         in_data_in.button_event    = req_chan.button_event;
         in_data_in.clock_hours     = req_chan.clock_hours;
         in_data_in.clock_minutes   = req_chan.clock_minutes;
         in_data_in.battery_percent = req_chan.battery_percent;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;

      rsp_data_in = advance ? rsp_next : rsp_data_ff;
   end

   assign req_chan.ready = !div_status.busy && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Response port
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mode          = rsp_data_ff.mode;
   assign rsp_chan.blink_phase   = rsp_data_ff.blink_phase;
   assign rsp_chan.edit_position = rsp_data_ff.edit_position;
   assign rsp_chan.hours_tens    = rsp_data_ff.hours_tens;
   assign rsp_chan.hours_units   = rsp_data_ff.hours_units;
   assign rsp_chan.minutes_tens  = rsp_data_ff.minutes_tens;
   assign rsp_chan.minutes_units = rsp_data_ff.minutes_units;
   assign rsp_chan.battery_level = rsp_data_ff.battery_level;
   assign rsp_chan.battery_blank = rsp_data_ff.battery_blank;
   assign rsp_chan.write_time    = rsp_data_ff.write_time;
   assign rsp_chan.write_hours   = rsp_data_ff.write_hours;
   assign rsp_chan.write_minutes = rsp_data_ff.write_minutes;

   // A time write always comes with the return to show time
   a_write_in_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.write_time |-> rsp_data_ff.mode == MODE_TIME)
      else $error("time write outside show time");

   // Blanking only while the battery is shown
   a_blank_in_batt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.battery_blank |-> rsp_data_ff.mode == MODE_BATT)
      else $error("battery blanking outside battery display");

   // Blink phase only in set time
   a_blink_in_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.blink_phase |-> rsp_data_ff.mode == MODE_SET)
      else $error("blink phase outside set time");

   // A request never enters while the blink phase is being recomputed
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_take)
      else $error("request accepted during blink recompute");

   // Every processed request lands in the response register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request lost");

endmodule

>>> sim/tb_watch_mode_and_time_set_control_core.sv
// Self-checking testbench for the watch mode and time-set controller core.
`timescale 1ns / 1ps

module tb_watch_mode_and_time_set_control_core;
   import wmtsc_pkg::*;

   // One directed request, with an optional settings load before it and an optional
   // hand-written expected status
   typedef struct {
      req_type stim;
      int      setting;
      bit      typed;
      rsp_type want;
   } step_row_t;

   logic clock;
   logic reset;
   logic                    csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   wmtsc_req_if req_bus ();
   wmtsc_rsp_if rsp_bus ();

   watch_mode_and_time_set_control_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted watch state and settings
   mode_type  w_mode;
   bit [15:0] w_display_left;
   bit [15:0] w_blink_ticks;
   bit        w_blink_on;
   bit [15:0] w_idle_ticks;
   bit [2:0]  w_edit;
   bit [3:0]  w_digit [4];
   bit [4:0]  w_saved_hours;
   bit [5:0]  w_saved_minutes;
   bit [6:0]  w_batt_level;
   bit [15:0] w_batt_left;
   bit [16:0] w_batt_count;
   cfg_type   w_cfg;

   rsp_type     status_due [$];
   int unsigned status_seen;
   int unsigned fault_count;
   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned rsp_hold_left;
   int unsigned quiet_ticks_left;

   step_row_t directed_steps [27];
   cfg_type   watch_settings [9];

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop
   initial begin
      #(10_000_000);
      $display("timeout: %0d statuses still due", status_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void resume_time_display();
      w_mode         = MODE_TIME;
      w_display_left = w_cfg.display_on_ms;
   endfunction

   // Advance the predicted watch by one tick and return the status it shows
   function automatic rsp_type advance_watch(input req_type r);
      event_type   ev;
      rsp_type     o;
      bit          done;
      bit [1:0]    d;
      bit [3:0]    v;
      int unsigned limit;
      int unsigned per;
      int unsigned h;
      int unsigned m;
      o    = '0;
      done = 1'b0;
      // codes above the last event act as no press
      ev = (r.button_event > 3'd4) ? EV_NONE : event_type'(r.button_event);
      case (w_mode)
         MODE_TIME: begin
            if (ev == EV_SW1_LONG) begin
               w_saved_hours   = r.clock_hours;
               w_saved_minutes = r.clock_minutes;
               w_digit[0]      = 4'(r.clock_hours / 10);
               w_digit[1]      = 4'(r.clock_hours % 10);
               w_digit[2]      = 4'(r.clock_minutes / 10);
               w_digit[3]      = 4'(r.clock_minutes % 10);
               w_edit          = '0;
               w_idle_ticks    = '0;
               w_blink_on      = 1'b1;
               w_blink_ticks   = '0;
               w_mode          = MODE_SET;
            end else if (ev == EV_SW2_LONG) begin
               w_batt_level = r.battery_percent;
               w_batt_left  = w_cfg.battery_show_ms;
               w_batt_count = '0;
               w_mode       = MODE_BATT;
            end else if (ev == EV_SW1_SHORT || ev == EV_SW2_SHORT) begin
               w_display_left = w_cfg.display_on_ms;
            end else begin
               if (w_display_left != 0) w_display_left--;
               if (w_display_left == 0) w_mode = MODE_SLEEP;
            end
         end
         MODE_SET: begin
            if (w_blink_ticks != '1) w_blink_ticks++;
            if (w_blink_ticks >= w_cfg.blink_period_ms) begin
               w_blink_on    = ~w_blink_on;
               w_blink_ticks = '0;
            end
            if (ev == EV_SW1_SHORT) begin
               // step the edited digit, wrapping above its limit
               d = w_edit[1:0];
               case (d)
                  2'd0:    limit = 2;
                  2'd1:    limit = (w_digit[0] == 4'd2) ? 3 : 9;
                  2'd2:    limit = 5;
                  default: limit = 9;
               endcase
               v = 4'(w_digit[d] + 4'd1);
               if (v > limit) v = '0;
               w_digit[d]    = v;
               w_idle_ticks  = '0;
               w_blink_on    = 1'b1;
               w_blink_ticks = '0;
            end else if (ev == EV_SW2_SHORT) begin
               w_edit       = 3'(w_edit + 3'd1);
               w_idle_ticks = '0;
               if (w_edit >= 3'd4) begin
                  // confirm: write the edited time, saturated to the field widths
                  h = w_digit[0] * 10 + w_digit[1];
                  m = w_digit[2] * 10 + w_digit[3];
                  o.write_time    = 1'b1;
                  o.write_hours   = (h > 31) ? 5'd31 : 5'(h);
                  o.write_minutes = (m > 63) ? 6'd63 : 6'(m);
                  resume_time_display();
                  done = 1'b1;
               end else begin
                  w_blink_on    = 1'b1;
                  w_blink_ticks = '0;
               end
            end else if (w_idle_ticks != '1) begin
               w_idle_ticks++;
            end
            // idle timeout cancels and restores the snapshot
            if (!done && w_idle_ticks >= w_cfg.set_timeout_ms) begin
               o.write_time    = 1'b1;
               o.write_hours   = w_saved_hours;
               o.write_minutes = w_saved_minutes;
               resume_time_display();
            end
         end
         MODE_BATT: begin
            per = (w_cfg.blink_period_ms == 0) ? 1 : w_cfg.blink_period_ms;
            if (w_batt_count != '1) w_batt_count++;
            if (w_batt_left != 0) w_batt_left--;
            if (w_batt_left == 0) begin
               resume_time_display();
            end else if (w_batt_level < w_cfg.low_battery_pct) begin
               o.battery_blank = 1'((w_batt_count / per) & 1);
            end
         end
         default: begin
            if (ev != EV_NONE) resume_time_display();
         end
      endcase
      o.mode          = w_mode;
      o.blink_phase   = (w_mode == MODE_SET) ? w_blink_on : 1'b0;
      o.edit_position = w_edit;
      o.hours_tens    = w_digit[0][1:0];
      o.hours_units   = w_digit[1];
      o.minutes_tens  = w_digit[2][2:0];
      o.minutes_units = w_digit[3];
      o.battery_level = w_batt_level;
      return o;
   endfunction

   // Random request, shaped by the predicted mode so that edit sequences and timeouts happen
   function automatic req_type pick_request();
      req_type     r;
      int unsigned roll;
      r.clock_hours     = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                                   : 5'($urandom_range(23));
      r.clock_minutes   = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(59));
      r.battery_percent = 7'($urandom_range(127));
      roll = $urandom_range(99);
      if (quiet_ticks_left > 0) begin
         // quiet stretch so that timers run out
         quiet_ticks_left--;
         r.button_event = (roll < 10) ? 3'($urandom_range(7, 5)) : EV_NONE;
      end else if (roll < 8) begin
         r.button_event = 3'($urandom_range(7));
      end else if (roll < 10) begin
         quiet_ticks_left = $urandom_range(40, 1);
         r.button_event   = EV_NONE;
      end else begin
         case (w_mode)
            MODE_TIME:
               r.button_event = (roll < 45) ? EV_SW1_LONG :
                                (roll < 60) ? EV_SW2_LONG :
                                (roll < 70) ? EV_SW1_SHORT :
                                (roll < 80) ? EV_SW2_SHORT : EV_NONE;
            MODE_SET:
               r.button_event = (roll < 50) ? EV_SW1_SHORT :
                                (roll < 80) ? EV_SW2_SHORT :
                                (roll < 92) ? EV_NONE : 3'($urandom_range(4));
            MODE_SLEEP:
               r.button_event = (roll < 60) ? 3'($urandom_range(4, 1)) : EV_NONE;
            default:
               r.button_event = (roll < 70) ? EV_NONE : 3'($urandom_range(4));
         endcase
      end
      return r;
   endfunction

   function automatic step_row_t row(input logic [2:0] ev, input int h, input int m,
                                     input int b, input int setting = -1);
      step_row_t s;
      s.stim    = '{button_event: ev, clock_hours: 5'(h), clock_minutes: 6'(m),
                    battery_percent: 7'(b)};
      s.setting = setting;
      s.typed   = 1'b0;
      s.want    = '0;
      return s;
   endfunction

   task automatic report_fault(input string what);
      if (fault_count < 50) $display("ERROR: %s", what);
      fault_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_fault($sformatf("status %0d %s: got %0d, expected %0d",
                                status_seen, name, got, want));
   endtask

   // Compare one accepted status with the oldest one due
   task automatic check_status();
      rsp_type got;
      rsp_type want;
      got = {rsp_bus.mode, rsp_bus.blink_phase, rsp_bus.edit_position, rsp_bus.hours_tens,
             rsp_bus.hours_units, rsp_bus.minutes_tens, rsp_bus.minutes_units,
             rsp_bus.battery_level, rsp_bus.battery_blank, rsp_bus.write_time,
             rsp_bus.write_hours, rsp_bus.write_minutes};
      status_seen++;
      if (status_due.size() == 0) begin
         report_fault($sformatf("status %0d arrived with none due", status_seen));
         return;
      end
      want = status_due.pop_front();
      check_field("mode", got.mode, want.mode);
      check_field("blink_phase", got.blink_phase, want.blink_phase);
      check_field("edit_position", got.edit_position, want.edit_position);
      check_field("hours_tens", got.hours_tens, want.hours_tens);
      check_field("hours_units", got.hours_units, want.hours_units);
      check_field("minutes_tens", got.minutes_tens, want.minutes_tens);
      check_field("minutes_units", got.minutes_units, want.minutes_units);
      check_field("battery_level", got.battery_level, want.battery_level);
      check_field("battery_blank", got.battery_blank, want.battery_blank);
      check_field("write_time", got.write_time, want.write_time);
      check_field("write_hours", got.write_hours, want.write_hours);
      check_field("write_minutes", got.write_minutes, want.write_minutes);
   endtask

   // Response side: random or held-off ready, checks every accepted status
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_status();
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offer one request, wait for it to be taken and queue its expected status
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.button_event    <= r.button_event;
      req_bus.clock_hours     <= r.clock_hours;
      req_bus.clock_minutes   <= r.clock_minutes;
      req_bus.battery_percent <= r.battery_percent;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predicted = advance_watch(r);
      status_due.push_back(typed ? typed_want : predicted);
   endtask

   // Stop sending and wait for every due status
   task automatic await_status_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (status_due.size() != 0) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [CFG_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Blink period goes last: its write keeps the request side busy for a while
   task automatic load_settings(input cfg_type c);
      put_csr(CSR_DISPLAY_ON, c.display_on_ms);
      put_csr(CSR_SET_TIMEOUT, c.set_timeout_ms);
      put_csr(CSR_BATTERY_SHOW, c.battery_show_ms);
      put_csr(CSR_LOW_BATTERY, CFG_BITS'(c.low_battery_pct));
      put_csr(CSR_BLINK_PERIOD, c.blink_period_ms);
      csr_wr_en <= 1'b0;
      w_cfg = c;
   endtask

   // Stimulus
   initial begin
      req_bus.valid           <= 1'b0;
      req_bus.button_event    <= EV_NONE;
      req_bus.clock_hours     <= '0;
      req_bus.clock_minutes   <= '0;
      req_bus.battery_percent <= '0;
      csr_wr_en               <= 1'b0;
      csr_index               <= CSR_DISPLAY_ON;
      csr_wdata               <= '0;
      reset                   <= 1'b1;
      send_idle_pct    = 0;
      rsp_idle_pct     = 0;
      rsp_hold_left    = 0;
      quiet_ticks_left = 0;
      status_seen      = 0;
      fault_count      = 0;

      // predicted state after reset
      w_cfg = '{DISPLAY_ON_RST, BLINK_PERIOD_RST, SET_TIMEOUT_RST, BATTERY_SHOW_RST,
                LOW_BATTERY_RST};
      w_mode          = MODE_TIME;
      w_display_left  = DISPLAY_ON_RST;
      w_blink_ticks   = '0;
      w_blink_on      = 1'b1;
      w_idle_ticks    = '0;
      w_edit          = '0;
      w_digit         = '{default: '0};
      w_saved_hours   = '0;
      w_saved_minutes = '0;
      w_batt_level    = '0;
      w_batt_left     = '0;
      w_batt_count    = '0;

      // settings: two for the directed part, then one per random phase
      watch_settings = '{
         '{16'd0,     16'd0,     16'd0,     16'd0,     7'd127},
         '{16'd8,     16'd0,     16'd10,    16'd6,     7'd100},
         '{16'd40,    16'd3,     16'd25,    16'd20,    7'd50},
         '{16'd1,     16'd1,     16'd1,     16'd1,     7'd0},
         '{16'd15,    16'd0,     16'd12,    16'd9,     7'd127},
         '{16'd30,    16'd7,     16'd40,    16'd30,    7'd100},
         '{16'd0,     16'd2,     16'd0,     16'd0,     7'd25},
         '{16'd20,    16'd5,     16'd18,    16'd12,    7'd60},
         '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 7'd127}
      };

      directed_steps = '{
         row(EV_NONE, 0, 0, 0),
         row(3'd7, 31, 63, 127),                 // unknown code acts as no press
         row(EV_SW1_LONG, 31, 63, 0),            // snapshot beyond the digit limits
         row(EV_SW2_SHORT, 0, 0, 0),
         row(EV_SW1_SHORT, 0, 0, 0),
         row(EV_SW2_SHORT, 0, 0, 0),
         row(EV_SW2_SHORT, 0, 0, 0),
         row(EV_SW1_SHORT, 0, 0, 0),
         row(EV_SW2_SHORT, 0, 0, 0),             // confirm 32:64, both saturate
         row(EV_SW1_LONG, 19, 0, 0),
         row(EV_SW1_SHORT, 0, 0, 0),             // hours become 29, not clamped
         row(EV_SW2_SHORT, 0, 0, 0),
         row(EV_SW1_SHORT, 0, 0, 0),             // units above limit wrap to zero
         row(EV_SW2_SHORT, 0, 0, 0),
         row(EV_SW2_SHORT, 0, 0, 0),
         row(EV_SW2_SHORT, 0, 0, 0, 0),          // confirm wins over zero timeout
         row(EV_NONE, 0, 0, 0),                  // zero display time: sleep
         row(3'd5, 0, 0, 0),
         row(EV_SW1_SHORT, 0, 0, 0),             // wake, press consumed
         row(EV_SW2_LONG, 0, 0, 100),
         row(EV_NONE, 0, 0, 0),                  // zero battery time
         row(EV_SW1_LONG, 23, 59, 0),
         row(EV_NONE, 0, 0, 0),                  // zero timeout: cancel and restore
         row(EV_SW2_LONG, 12, 30, 99, 1),        // low battery, blink period of one
         row(EV_NONE, 0, 0, 0),
         row(EV_SW1_LONG, 0, 0, 0),              // ignored in battery display
         row(EV_NONE, 0, 0, 0)
      };
      directed_steps[0].typed = 1'b1;
      directed_steps[1].typed = 1'b1;
      directed_steps[2].typed = 1'b1;
      directed_steps[2].want  = '{mode: MODE_SET, blink_phase: 1'b1, hours_tens: 2'd3,
                                  hours_units: 4'd1, minutes_tens: 3'd6,
                                  minutes_units: 4'd3, default: '0};
      directed_steps[8].typed = 1'b1;
      directed_steps[8].want  = '{mode: MODE_TIME, edit_position: 3'd4, hours_tens: 2'd3,
                                  hours_units: 4'd2, minutes_tens: 3'd6,
                                  minutes_units: 4'd4, write_time: 1'b1,
                                  write_hours: 5'd31, write_minutes: 6'd63, default: '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_steps[i]) begin
         if (directed_steps[i].setting >= 0) begin
            await_status_drain();
            load_settings(watch_settings[directed_steps[i].setting]);
         end
         send_request(directed_steps[i].stim, directed_steps[i].typed, directed_steps[i].want);
      end

      // random phases: slow receiver, then slow sender, then full rate
      for (int p = 0; p < 7; p++) begin
         await_status_drain();
         load_settings(watch_settings[p + 2]);
         send_idle_pct = (p < 2) ? 19 : (p < 4) ? 80 : 0;
         rsp_idle_pct  = (p < 2) ? 80 : (p < 4) ? 19 : 0;
         for (int n = 0; n < ((p == 6) ? 100 : 230); n++) begin
            if (p == 4 && n == 100) rsp_hold_left = 60;   // fill the pipeline
            if (p == 5 && n == 100) await_status_drain();
            send_request(pick_request(), 1'b0, '0);
         end
      end

      await_status_drain();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && status_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
